// ----- sv/socu_pkg.sv -----
// ----------------------------------------------------------------------------
// socu_pkg
// Shared types and constants of the strength-of-connection unit: request and
// result payloads, register map, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package socu_pkg;

   // Row buffer depth default
   localparam int ROW_ENTRIES_DEF = 64;

   // Field widths
   localparam int COL_W   = 24;
   localparam int VAL_W   = 32;
   localparam int THETA_W = 16;
   localparam int FILT_W  = 31;
   localparam int REND_W  = 25;

   // CSR port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int CSR_IW = CSR_AW - 2;

   localparam logic [CSR_IW-1:0] CSR_MODE   = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_THETA  = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] CSR_FILTER = CSR_IW'(2);
   localparam logic [CSR_IW-1:0] CSR_RBEGIN = CSR_IW'(3);
   localparam logic [CSR_IW-1:0] CSR_REND   = CSR_IW'(4);

   // Register reset values
   localparam logic               MODE_RST   = 1'b0;
   localparam logic [THETA_W-1:0] THETA_RST  = THETA_W'(16384);
   localparam logic [FILT_W-1:0]  FILTER_RST = '0;
   localparam logic [COL_W-1:0]   RBEGIN_RST = '0;
   localparam logic [REND_W-1:0]  REND_RST   = REND_W'(25'h100_0000);

   // Mode codes
   localparam logic MODE_CLASSICAL = 1'b0;
   localparam logic MODE_GENERAL   = 1'b1;

   typedef struct packed {
      logic [COL_W-1:0]        row_id;
      logic [COL_W-1:0]        column;
      logic signed [VAL_W-1:0] entry_value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]        out_column;
      logic signed [VAL_W-1:0] out_value;
      logic                    strong_res;
      logic                    in_range;
      logic                    last_of_row;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic               mode;
      logic [THETA_W-1:0] theta;
      logic [FILT_W-1:0]  filter_threshold;
      logic [COL_W-1:0]   range_begin;
      logic [REND_W-1:0]  range_stop;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic take;      // request accepted this cycle
      logic prep;      // form the strength bound, read first buffer entry
      logic load;      // load one kept entry into the result register
      logic ovf_load;  // load the overflow result
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic row_ovf;    // current request finds the row overflowed
      logic row_empty;  // nothing kept in the row after current request
      logic emit_last;  // entry being emitted is the final one
      logic out_free;   // result register can take a new result
   } dp_status_type;

endpackage

// ----- sv/socu_regs.sv -----
// ----------------------------------------------------------------------------
// socu_regs
// APB-style configuration registers: mode, strength threshold, filter
// threshold and owned column range.
// ----------------------------------------------------------------------------
module socu_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [socu_pkg::CSR_AW-1:0]    paddr,
   input  logic [socu_pkg::CSR_DW-1:0]    pwdata,
   output logic [socu_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output socu_pkg::cfg_type              cfg
);
   import socu_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              wr_en;
   logic [CSR_IW-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_AW-1:2];

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_MODE:   cfg_in.mode             = pwdata[0];
            CSR_THETA:  cfg_in.theta            = pwdata[THETA_W-1:0];
            CSR_FILTER: cfg_in.filter_threshold = pwdata[FILT_W-1:0];
            CSR_RBEGIN: cfg_in.range_begin      = pwdata[COL_W-1:0];
            CSR_REND:   cfg_in.range_stop       = pwdata[REND_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= MODE_RST;
         cfg_ff.theta            <= THETA_RST;
         cfg_ff.filter_threshold <= FILTER_RST;
         cfg_ff.range_begin      <= RBEGIN_RST;
         cfg_ff.range_stop       <= REND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         CSR_MODE:   prdata = CSR_DW'(cfg_ff.mode);
         CSR_THETA:  prdata = CSR_DW'(cfg_ff.theta);
         CSR_FILTER: prdata = CSR_DW'(cfg_ff.filter_threshold);
         CSR_RBEGIN: prdata = CSR_DW'(cfg_ff.range_begin);
         CSR_REND:   prdata = CSR_DW'(cfg_ff.range_stop);
         default:    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/socu_datapath.sv -----
// ----------------------------------------------------------------------------
// socu_datapath
// Row state, kept-entry buffer, strength bound multiplier and the result
// register. Driven by commands from socu_ctrl.
// ----------------------------------------------------------------------------
module socu_datapath #(
   parameter int MAX_ROW_ENTRIES = socu_pkg::ROW_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  socu_pkg::cfg_type        cfg,
   input  socu_pkg::req_type        req_data,
   input  socu_pkg::dp_cmd_type     cmd,
   output socu_pkg::dp_status_type  status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output socu_pkg::rsp_type        rsp_data
);
   import socu_pkg::*;

   localparam int AW = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ROW_ENTRIES + 1);
   localparam int MW = COL_W + VAL_W;
   localparam int PW = THETA_W + VAL_W + 2;

   // Row state
   logic [CW-1:0]           kept_ff, kept_in, kept_upd;
   logic [CW-1:0]           raw_ff, raw_in, raw_upd;
   logic [VAL_W-1:0]        run_ff, run_in, run_upd;
   logic                    seen_ff, seen_in, seen_upd;
   logic                    ovf_ff, ovf_in, ovf_now;
   logic [VAL_W-1:0]        first_ff, first_upd;

   // Emission state
   logic [CW-1:0]           cnt_ff;
   logic [CW-1:0]           idx_ff, idx_nxt;
   logic [COL_W-1:0]        row_ff;
   logic signed [VAL_W:0]   eop_ff, eop_upd;
   logic signed [PW-1:0]    rhs_ff, rhs_in;

   // Buffer
   logic [MW-1:0]           mem [MAX_ROW_ENTRIES];
   logic [MW-1:0]           rdata_ff;
   logic [AW-1:0]           rd_addr;

   // Result register
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Entry evaluation
   logic signed [VAL_W:0]   v33, abs_v;
   logic [VAL_W-1:0]        mag;
   logic                    keep, offd, better;
   logic signed [VAL_W:0]   ext33;

   // Emit evaluation
   logic [COL_W-1:0]        e_col;
   logic signed [VAL_W-1:0] e_val;
   logic signed [VAL_W:0]   x33, lhs33;
   logic signed [PW-1:0]    lhs_sh;
   logic                    inr, dep;
   logic                    out_free;

   // Incoming entry: magnitude, filter and extremum update
   assign v33     = {req_data.entry_value[VAL_W-1], req_data.entry_value};
   assign abs_v   = req_data.entry_value[VAL_W-1] ? -v33 : v33;
   assign mag     = abs_v[VAL_W-1:0];
   assign ovf_now = ovf_ff | (raw_ff >= CW'(MAX_ROW_ENTRIES));
   assign keep    = !ovf_now && ({1'b0, mag} > {2'b00, cfg.filter_threshold});
   assign offd    = req_data.column != req_data.row_id;

   always_comb begin
      if (cfg.mode == MODE_GENERAL) begin
         better = !seen_ff || (mag > run_ff);
      end else begin
         better = !seen_ff || (req_data.entry_value < $signed(run_ff));
      end
   end

   always_comb begin
      kept_upd  = kept_ff;
      raw_upd   = ovf_now ? raw_ff : raw_ff + CW'(1);
      run_upd   = run_ff;
      seen_upd  = seen_ff;
      first_upd = first_ff;
      if (keep) begin
         kept_upd = kept_ff + CW'(1);
         if (kept_ff == '0) begin
            first_upd = req_data.entry_value;
         end
         if (offd) begin
            seen_upd = 1'b1;
            if (better) begin
               run_upd = (cfg.mode == MODE_GENERAL) ? mag : req_data.entry_value;
            end
         end
      end
   end

   // Extremum as signed operand of the strength test
   always_comb begin
      if (seen_upd) begin
         ext33 = (cfg.mode == MODE_GENERAL) ? $signed({1'b0, run_upd})
                                            : $signed({run_upd[VAL_W-1], run_upd});
      end else begin
         ext33 = $signed({first_upd[VAL_W-1], first_upd});
      end
      if (cfg.mode == MODE_GENERAL) begin
         eop_upd = (ext33 < 0) ? -ext33 : ext33;
      end else begin
         eop_upd = -ext33;
      end
   end

   // Row state next values; the row returns to reset after its last entry
   always_comb begin
      kept_in = kept_ff;
      raw_in  = raw_ff;
      run_in  = run_ff;
      seen_in = seen_ff;
      ovf_in  = ovf_ff;
      if (cmd.take) begin
         if (req_data.last) begin
            kept_in = '0;
            raw_in  = '0;
            run_in  = '0;
            seen_in = 1'b0;
            ovf_in  = 1'b0;
         end else begin
            kept_in = kept_upd;
            raw_in  = raw_upd;
            run_in  = run_upd;
            seen_in = seen_upd;
            ovf_in  = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
         raw_ff  <= '0;
         run_ff  <= '0;
         seen_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         kept_ff <= kept_in;
         raw_ff  <= raw_in;
         run_ff  <= run_in;
         seen_ff <= seen_in;
         ovf_ff  <= ovf_in;
      end
   end

   // Row payload captured at the end of a row
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         first_ff <= first_upd;
         if (req_data.last) begin
            cnt_ff <= kept_upd;
            row_ff <= req_data.row_id;
            eop_ff <= eop_upd;
         end
      end
   end

   // Strength bound theta * e, formed once per row
   assign rhs_in = $signed({1'b0, cfg.theta}) * eop_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rhs_ff <= rhs_in;
      end
   end

   // Emit index
   assign idx_nxt = idx_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         idx_ff <= '0;
      end else if (cmd.load) begin
         idx_ff <= idx_nxt;
      end
   end

   // Kept-entry buffer, one write and one registered read per cycle
   always_comb begin
      if (cmd.prep) begin
         rd_addr = '0;
      end else if (cmd.load) begin
         rd_addr = idx_nxt[AW-1:0];
      end else begin
         rd_addr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && keep) begin
         mem[kept_ff[AW-1:0]] <= {req_data.column, req_data.entry_value};
      end
      rdata_ff <= mem[rd_addr];
   end

   // Strength and range test on the buffered entry
   assign e_col  = rdata_ff[MW-1:VAL_W];
   assign e_val  = rdata_ff[VAL_W-1:0];
   assign x33    = {e_val[VAL_W-1], e_val};
   assign lhs33  = (cfg.mode == MODE_GENERAL) ? ((x33 < 0) ? -x33 : x33) : -x33;
   assign lhs_sh = $signed({lhs33[VAL_W], lhs33, 16'b0});
   assign inr    = (e_col >= cfg.range_begin) && ({1'b0, e_col} < cfg.range_stop);
   assign dep    = (lhs_sh > rhs_ff) && (e_col != row_ff) && inr;

   // Result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         rsp_in.out_column  = e_col;
         rsp_in.out_value   = e_val;
         rsp_in.strong_res  = dep;
         rsp_in.in_range    = inr;
         rsp_in.last_of_row = idx_nxt == cnt_ff;
         rsp_in.overflow    = 1'b0;
         rsp_valid_in       = 1'b1;
      end else if (cmd.ovf_load) begin
         rsp_in          = '0;
         rsp_in.overflow = 1'b1;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to controller
   assign status.row_ovf   = ovf_now;
   assign status.row_empty = kept_upd == '0;
   assign status.emit_last = idx_nxt == cnt_ff;
   assign status.out_free  = out_free;

endmodule

// ----- sv/socu_ctrl.sv -----
// ----------------------------------------------------------------------------
// socu_ctrl
// Row sequencer: collects entries, then drives emission of the kept entries
// or of the overflow result.
// ----------------------------------------------------------------------------
module socu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last,
   output logic                     req_ready,
   input  socu_pkg::dp_status_type  status,
   output socu_pkg::dp_cmd_type     cmd
);
   import socu_pkg::*;

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_PREP    = 2'd1;
   localparam logic [1:0] ST_EMIT    = 2'd2;
   localparam logic [1:0] ST_OVF     = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       take;

   assign req_ready = state_ff == ST_COLLECT;
   assign take      = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.take     = take;
      cmd.prep     = 1'b0;
      cmd.load     = 1'b0;
      cmd.ovf_load = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (take && req_last) begin
               priority if (status.row_ovf) begin
                  state_in = ST_OVF;
               end else if (!status.row_empty) begin
                  state_in = ST_PREP;
               end else begin
                  // nothing kept: no result, keep collecting
                  state_in = ST_COLLECT;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.load = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_COLLECT;
            end
         end
         ST_OVF: begin
            cmd.ovf_load = status.out_free;
            if (status.out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/amg_strength_of_connection_unit.sv -----
// ----------------------------------------------------------------------------
// amg_strength_of_connection_unit
// Strength-of-connection filter for one sparse matrix row.
// ----------------------------------------------------------------------------
// Entries of a row enter on the req_ channel (valid/ready), one per cycle
// while the unit collects a row. Entries with magnitude at or below the
// filter threshold are dropped; kept ones go into a row buffer of
// MAX_ROW_ENTRIES entries while the off-diagonal extremum is tracked.
// After the entry marked last, req_ready drops unless the row neither
// overflowed nor kept an entry; the PREP state forms the strength bound
// (one 17x33 multiply), then kept entries leave on the rsp_ channel at
// one per cycle while the output register is free, from the buffer's
// registered read port. A row of more than MAX_ROW_ENTRIES entries gives
// a single overflow result instead, loaded by the OVF state.
// Results wait in an output register while rsp_ready is low; emission
// pauses meanwhile, and once a row is fully emitted the next row is
// accepted even if its final result is still waiting. Reset clears the
// row state, the result valid and the configuration registers; the
// buffer needs no clearing. Configure through the APB port while idle.
// ----------------------------------------------------------------------------
module amg_strength_of_connection_unit #(
   parameter int MAX_ROW_ENTRIES = socu_pkg::ROW_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  socu_pkg::req_type            req_data,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output socu_pkg::rsp_type            rsp_data,
   // Configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [socu_pkg::CSR_AW-1:0]  paddr,
   input  logic [socu_pkg::CSR_DW-1:0]  pwdata,
   output logic [socu_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import socu_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers
   socu_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   socu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Row buffer and arithmetic
   socu_datapath #(
      .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
